### design/lass_pkg.sv
// Shared constants, types and controller interface of the late acceptance search step.
package lass_pkg;

	localparam int HIST_DEPTH = 16;
	localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
	localparam int COST_W     = 32;
	localparam int TENTHS_W   = 36;
	localparam int LEN_W      = 5;
	localparam int BEST_W     = 33;
	localparam int DIV_BIT_W  = $clog2(COST_W);
	localparam int IN_W       = 32;
	localparam int OUT_W      = 104;
	localparam int CFG_AW     = 2;
	localparam int CFG_DW     = 32;

	typedef enum logic [CFG_AW-1:0] {
		CFG_HISTORY_LEN = 2'd0,
		CFG_MAX_EVALS   = 2'd1,
		CFG_SAVE_PERIOD = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_DIV,
		ST_READ,
		ST_DECIDE,
		ST_SCAN,
		ST_SCAN_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic fill;
		logic div_step;
		logic read_slot;
		logic decide;
		logic scan_step;
		logic scan_done;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic started;
		logic dirty;
		logic fill_last;
		logic div_last;
		logic out_free;
		logic rescan;
		logic scan_last;
	} sts_t;

endpackage

### design/lass_ctrl.sv
// Controller state machine of the late acceptance search step.
module lass_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lass_pkg::sts_t sts,
	output lass_pkg::cmd_t cmd
);
	import lass_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (!sts.started) begin
						state_d = ST_FILL;
					end else if (sts.dirty) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_DECIDE;
					end
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) begin
					state_d = sts.dirty ? ST_DIV : ST_READ;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read_slot = 1'b1;
				state_d       = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.out_free) begin
					cmd.decide = 1'b1;
					state_d    = sts.rescan ? ST_SCAN : ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_SCAN_DONE;
				end
			end
			ST_SCAN_DONE: begin
				cmd.scan_done = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### design/lass_datapath.sv
// Datapath of the late acceptance search step: registers, history memory and result register.
module lass_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lass_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [lass_pkg::CFG_DW-1:0]   cfg_data,
	input  logic [lass_pkg::IN_W-1:0]     in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lass_pkg::OUT_W-1:0]    out_data,
	input  lass_pkg::cmd_t                cmd,
	output lass_pkg::sts_t                sts
);
	import lass_pkg::*;

	// Configuration registers.
	logic [LEN_W-1:0]  hist_len_q;
	logic [COST_W-1:0] max_evals_q;
	logic [COST_W-1:0] save_period_q;
	logic              dirty_q;

	// Search state.
	logic [TENTHS_W-1:0] limit_q;
	logic [CNT_W-1:0]    limit_cnt_q;
	logic [COST_W-1:0]   current_q;
	logic [BEST_W-1:0]   best_q;
	logic [HIST_AW-1:0]  slot_ptr_q;
	logic [COST_W-1:0]   evals_q;
	logic [COST_W-1:0]   rem_q;
	logic [DIV_BIT_W-1:0] div_bit_q;
	logic                started_q;

	// Item under work.
	logic [COST_W-1:0]   cost_q;
	logic [TENTHS_W-1:0] tenths_q;

	// Fill and rescan.
	logic [HIST_AW-1:0]  fill_idx_q;
	logic [HIST_AW-1:0]  scan_idx_q;
	logic [TENTHS_W-1:0] top_q;
	logic [CNT_W-1:0]    top_cnt_q;

	// History memory.
	logic [TENTHS_W-1:0] mem [HIST_DEPTH];
	logic [TENTHS_W-1:0] rd_q;
	logic                mem_we;
	logic [HIST_AW-1:0]  mem_wa;
	logic [TENTHS_W-1:0] mem_wd;
	logic                mem_re;
	logic [HIST_AW-1:0]  mem_ra;

	// Result register.
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	// Combinational helpers.
	logic [CNT_W-1:0]    n_used;
	logic [HIST_AW-1:0]  slot;
	logic [CNT_W-1:0]    slot_inc;
	logic [HIST_AW-1:0]  slot_next;
	logic [TENTHS_W-1:0] in_tenths;
	logic [TENTHS_W-1:0] in_limit;
	logic [COST_W-1:0]   in_cost;
	logic                acc;
	logic                better;
	logic                grow;
	logic                shrink;
	logic                hit_top;
	logic [CNT_W-1:0]    cnt_after;
	logic [COST_W-1:0]   cur_after;
	logic [BEST_W-1:0]   best_after;
	logic                autosave;
	logic                finished;
	logic [COST_W:0]     div_t;
	logic [COST_W:0]     div_sub;
	logic [TENTHS_W-1:0] top_next;
	logic [CNT_W-1:0]    top_cnt_next;

	assign in_cost   = in_data[COST_W-1:0];
	assign in_tenths = {1'b0, in_cost, 3'b000} + {3'b000, in_cost, 1'b0};
	assign in_limit  = {1'b0, in_cost, 3'b000} + {3'b000, in_cost, 1'b0}
		+ {4'b0000, in_cost};

	// A length of zero acts as one slot, and any length beyond the depth as the full depth.
	always_comb begin
		if (hist_len_q == '0) begin
			n_used = CNT_W'(1);
		end else if (32'(hist_len_q) > 32'(HIST_DEPTH)) begin
			n_used = CNT_W'(HIST_DEPTH);
		end else begin
			n_used = CNT_W'(hist_len_q);
		end
	end

	// A pointer left beyond a shortened list restarts at the first slot.
	assign slot      = (CNT_W'(slot_ptr_q) >= n_used) ? '0 : slot_ptr_q;
	assign slot_inc  = CNT_W'(slot) + CNT_W'(1);
	assign slot_next = (slot_inc >= n_used) ? '0 : slot_inc[HIST_AW-1:0];

	// Acceptance decision on the slot value read from the history.
	assign acc        = (cost_q == current_q) || (tenths_q < limit_q);
	assign better     = {1'b0, cost_q} < best_q;
	assign grow       = tenths_q > rd_q;
	assign shrink     = (tenths_q < rd_q) && (cost_q < current_q);
	assign hit_top    = (rd_q == limit_q) && (limit_cnt_q != '0);
	assign cnt_after  = hit_top ? limit_cnt_q - CNT_W'(1) : limit_cnt_q;
	assign cur_after  = acc ? cost_q : current_q;
	assign best_after = (acc && better) ? {1'b0, cost_q} : best_q;
	assign autosave   = (save_period_q != '0) && (rem_q == '0);
	assign finished   = evals_q >= max_evals_q;

	// One step of the restoring remainder of the evaluation count by the save period.
	assign div_t   = {rem_q, evals_q[div_bit_q]};
	assign div_sub = div_t - {1'b0, save_period_q};

	// Running maximum and its count over the history during a rescan.
	always_comb begin
		top_next     = top_q;
		top_cnt_next = top_cnt_q;
		if (rd_q > top_q) begin
			top_next     = rd_q;
			top_cnt_next = CNT_W'(1);
		end else if (rd_q == top_q) begin
			top_cnt_next = top_cnt_q + CNT_W'(1);
		end
	end

	// Memory port selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot;
		mem_wd = tenths_q;
		mem_re = 1'b0;
		mem_ra = slot;
		if (cmd.fill) begin
			mem_we = 1'b1;
			mem_wa = fill_idx_q;
			mem_wd = limit_q;
		end else if (cmd.decide) begin
			mem_we = acc && (grow || shrink);
		end
		if (cmd.accept || cmd.read_slot) begin
			mem_re = 1'b1;
		end else if (cmd.scan_step) begin
			mem_re = 1'b1;
			mem_ra = scan_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// Item payload and rescan accumulators.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cost_q   <= in_cost;
			tenths_q <= in_tenths;
		end
		if (cmd.decide) begin
			top_q     <= '0;
			top_cnt_q <= '0;
		end else if (cmd.scan_step && scan_idx_q != '0) begin
			top_q     <= top_next;
			top_cnt_q <= top_cnt_next;
		end
		if (cmd.decide) begin
			out_data_q <= {4'b0000, evals_q, best_after[COST_W-1:0], cur_after,
				finished, autosave, acc && better, acc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_len_q    <= LEN_W'(16);
			max_evals_q   <= '0;
			save_period_q <= '0;
			dirty_q       <= 1'b0;
			limit_q       <= '1;
			limit_cnt_q   <= '0;
			current_q     <= '1;
			best_q        <= {1'b1, {COST_W{1'b0}}};
			slot_ptr_q    <= '0;
			evals_q       <= '0;
			rem_q         <= '0;
			div_bit_q     <= '0;
			started_q     <= 1'b0;
			fill_idx_q    <= '0;
			scan_idx_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_HISTORY_LEN: hist_len_q <= cfg_data[LEN_W-1:0];
					CFG_MAX_EVALS:   max_evals_q <= cfg_data;
					CFG_SAVE_PERIOD: begin
						save_period_q <= cfg_data;
						dirty_q       <= 1'b1;
					end
					default: ;
				endcase
			end

			if (cmd.accept) begin
				if (evals_q != '1) begin
					evals_q <= evals_q + COST_W'(1);
					if (!dirty_q) begin
						rem_q <= (rem_q + COST_W'(1) == save_period_q) ? '0
							: rem_q + COST_W'(1);
					end
				end
				if (dirty_q) begin
					rem_q     <= '0;
					div_bit_q <= DIV_BIT_W'(COST_W - 1);
				end
				if (!started_q) begin
					limit_q     <= in_limit;
					current_q   <= in_cost;
					limit_cnt_q <= n_used;
					started_q   <= 1'b1;
				end
				fill_idx_q <= '0;
			end

			if (cmd.fill) begin
				fill_idx_q <= fill_idx_q + HIST_AW'(1);
			end

			if (cmd.div_step) begin
				rem_q     <= div_sub[COST_W] ? div_t[COST_W-1:0] : div_sub[COST_W-1:0];
				div_bit_q <= div_bit_q - DIV_BIT_W'(1);
				if (div_bit_q == '0) begin
					dirty_q <= 1'b0;
				end
			end

			if (cmd.decide) begin
				current_q  <= cur_after;
				best_q     <= best_after;
				slot_ptr_q <= slot_next;
				scan_idx_q <= '0;
				if (acc && !grow && shrink) begin
					limit_cnt_q <= cnt_after;
				end
			end

			if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + HIST_AW'(1);
			end

			if (cmd.scan_done) begin
				limit_q     <= top_next;
				limit_cnt_q <= top_cnt_next;
			end

			if (cmd.decide) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign sts.started   = started_q;
	assign sts.dirty     = dirty_q;
	assign sts.fill_last = fill_idx_q == HIST_AW'(HIST_DEPTH - 1);
	assign sts.div_last  = div_bit_q == '0;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.rescan    = acc && !grow && shrink && (cnt_after == '0);
	assign sts.scan_last = CNT_W'(scan_idx_q) == n_used - CNT_W'(1);

endmodule

### design/late_acceptance_search_step_top.sv
// Top level of the late acceptance search step: controller and datapath.
//
//  Channel   Direction  Handshake                  Payload
//  s_axis    in         s_axis_tvalid/tready       tdata[31:0] cost
//  m_axis    out        m_axis_tvalid/tready       tdata[103:0] flags, costs, count
//  cfg       in         cfg_valid/cfg_ready        cfg_addr register index, cfg_data
//
// An item's cost is taken while its history slot is read, then the decision writes the
// result register, and the slot if an accepted cost grows or shrinks it. The first item
// after reset also fills and rereads the history; the first after a save period write
// also runs the bit-serial remainder of the evaluation count and a reread. A rescan for a
// new maximum reads the slots in use. Reset clears all control state. A stalled result
// holds the decision, so one further cost is taken; configuration is always taken.
module late_acceptance_search_step_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [31:0] cost
	input  logic [lass_pkg::IN_W-1:0]     s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [0] accepted, [1] improved, [2] autosave, [3] finished,
	// [35:4] current_cost_out, [67:36] best_cost_out, [99:68] eval_count, rest zero
	output logic [lass_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lass_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [lass_pkg::CFG_DW-1:0]   cfg_data
);
	import lass_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Registers are plain flops, so a write is always taken.
	assign cfg_ready = 1'b1;

	lass_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lass_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
